### rtl/spacewire_link_init_fsm_defines.svh
// Assertion macros for the link start-up top level.
`ifndef SPACEWIRE_LINK_INIT_FSM_DEFINES_SVH
`define SPACEWIRE_LINK_INIT_FSM_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define SWL_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("swl assertion failed");

// next-cycle implication
`define SWL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("swl assertion failed");

`else

`define SWL_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define SWL_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### rtl/swl_pkg.sv
`timescale 1ns / 1ps

package swl_pkg;

   localparam int CFG_W    = 16;
   localparam int LEN_W    = 16;
   localparam int TX_W     = CFG_W + LEN_W;
   localparam int CFG_IDX_W = 3;

   localparam logic [CFG_W-1:0] RESET_HOLD_RST  = CFG_W'(640);
   localparam logic [CFG_W-1:0] WAIT_HOLD_RST   = CFG_W'(1280);
   localparam logic [CFG_W-1:0] SILENCE_RST     = CFG_W'(1280);
   localparam logic [CFG_W-1:0] CHAR_PERIOD_RST = CFG_W'(5);
   localparam logic [CFG_W-1:0] TICKS_BYTE_RST  = CFG_W'(8);

   typedef enum logic [CFG_IDX_W-1:0] {
      CFG_RESET_HOLD     = 3'd0,
      CFG_WAIT_HOLD      = 3'd1,
      CFG_SILENCE        = 3'd2,
      CFG_CHAR_PERIOD    = 3'd3,
      CFG_TICKS_PER_BYTE = 3'd4
   } cfg_idx_type;

   typedef enum logic [2:0] {
      FN_TICK       = 3'd0,
      FN_NULL_RX    = 3'd1,
      FN_FCT_RX     = 3'd2,
      FN_PKT_RX     = 3'd3,
      FN_LINK_LOST  = 3'd4,
      FN_TX_START   = 3'd5,
      FN_LINK_START = 3'd6,
      FN_SHUTDOWN   = 3'd7
   } func_type;

   typedef enum logic [2:0] {
      LS_DOWN       = 3'd0,
      LS_ERESET     = 3'd1,
      LS_EWAIT      = 3'd2,
      LS_READY      = 3'd3,
      LS_STARTED    = 3'd4,
      LS_CONNECTING = 3'd5,
      LS_RUN        = 3'd6,
      LS_BUSY       = 3'd7
   } link_code_type;

   typedef enum logic [7:0] {
      ST_DOWN       = 8'b0000_0001,
      ST_ERESET     = 8'b0000_0010,
      ST_EWAIT      = 8'b0000_0100,
      ST_READY      = 8'b0000_1000,
      ST_STARTED    = 8'b0001_0000,
      ST_CONNECTING = 8'b0010_0000,
      ST_RUN        = 8'b0100_0000,
      ST_BUSY       = 8'b1000_0000
   } mode_type;

   typedef struct packed {
      logic [CFG_W-1:0] reset_hold;
      logic [CFG_W-1:0] wait_hold;
      logic [CFG_W-1:0] silence;
      logic [CFG_W-1:0] char_period;
      logic [CFG_W-1:0] ticks_per_byte;
   } cfg_type;

   typedef struct packed {
      func_type         func;
      logic             parity_bad;
      logic [LEN_W-1:0] byte_count;
   } item_type;

   typedef struct packed {
      link_code_type link_state;
      logic          send_null;
      logic          send_fct;
      logic          link_ready;
      logic          tx_done;
      logic          rx_accept;
      logic          tx_rejected;
      logic          error_notify;
   } result_type;

   function automatic link_code_type mode_code(input mode_type mode);
      link_code_type code;
      unique case (mode)
         ST_DOWN:       code = LS_DOWN;
         ST_ERESET:     code = LS_ERESET;
         ST_EWAIT:      code = LS_EWAIT;
         ST_READY:      code = LS_READY;
         ST_STARTED:    code = LS_STARTED;
         ST_CONNECTING: code = LS_CONNECTING;
         ST_RUN:        code = LS_RUN;
         ST_BUSY:       code = LS_BUSY;
         default:       code = LS_DOWN;
      endcase
      return code;
   endfunction

endpackage

### rtl/swl_csr.sv
`timescale 1ns / 1ps

module swl_csr import swl_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CFG_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (cfg_idx_type'(csr_index))
            CFG_RESET_HOLD:     cfg_in.reset_hold     = csr_wdata;
            CFG_WAIT_HOLD:      cfg_in.wait_hold      = csr_wdata;
            CFG_SILENCE:        cfg_in.silence        = csr_wdata;
            CFG_CHAR_PERIOD:    cfg_in.char_period    = csr_wdata;
            CFG_TICKS_PER_BYTE: cfg_in.ticks_per_byte = csr_wdata;
            // writes past the last register are dropped
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_hold     <= RESET_HOLD_RST;
         cfg_ff.wait_hold      <= WAIT_HOLD_RST;
         cfg_ff.silence        <= SILENCE_RST;
         cfg_ff.char_period    <= CHAR_PERIOD_RST;
         cfg_ff.ticks_per_byte <= TICKS_BYTE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/swl_core.sv
`timescale 1ns / 1ps

module swl_core import swl_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  item_type   item,
   input  cfg_type    cfg,
   output result_type result
);

   mode_type          mode_ff, mode_in;
   logic [CFG_W-1:0]  phase_ff, phase_in;
   logic [CFG_W-1:0]  char_ff, char_in;
   logic [TX_W-1:0]   tx_ff, tx_in;
   logic              silence_ff, silence_in;

   logic              phase_exp, char_exp, tx_exp;
   logic              go_ereset, go_silence;
   logic [TX_W-1:0]   tx_load;

   assign phase_exp = (phase_ff <= CFG_W'(1));
   assign char_exp  = (char_ff <= CFG_W'(1));
   assign tx_exp    = (tx_ff <= TX_W'(1));
   assign tx_load   = TX_W'(item.byte_count) * TX_W'(cfg.ticks_per_byte);

   always_comb begin
      mode_in    = mode_ff;
      phase_in   = phase_ff;
      char_in    = char_ff;
      tx_in      = tx_ff;
      silence_in = silence_ff;
      go_ereset  = 1'b0;
      go_silence = 1'b0;
      result     = '0;

      unique case (item.func)
         FN_TICK: begin
            unique case (mode_ff)
               ST_ERESET: begin
                  if (phase_exp) begin
                     if (silence_ff) begin
                        go_ereset = 1'b1;
                     end else begin
                        mode_in  = ST_EWAIT;
                        phase_in = cfg.wait_hold;
                     end
                  end else begin
                     phase_in = phase_ff - CFG_W'(1);
                  end
               end
               ST_EWAIT: begin
                  // ready is skipped on the way to started
                  if (phase_exp) begin
                     mode_in          = ST_STARTED;
                     phase_in         = cfg.wait_hold;
                     char_in          = cfg.char_period;
                     result.send_null = 1'b1;
                  end else begin
                     phase_in = phase_ff - CFG_W'(1);
                  end
               end
               ST_STARTED, ST_CONNECTING: begin
                  if (phase_exp) begin
                     go_ereset = 1'b1;
                  end else begin
                     phase_in = phase_ff - CFG_W'(1);
                     if (char_exp) begin
                        char_in = cfg.char_period;
                        if (mode_ff == ST_STARTED) begin
                           result.send_null = 1'b1;
                        end else begin
                           result.send_fct = 1'b1;
                        end
                     end else begin
                        char_in = char_ff - CFG_W'(1);
                     end
                  end
               end
               ST_BUSY: begin
                  if (tx_exp) begin
                     mode_in           = ST_RUN;
                     tx_in             = '0;
                     result.tx_done    = 1'b1;
                     result.link_ready = 1'b1;
                  end else begin
                     tx_in = tx_ff - TX_W'(1);
                  end
               end
               default: ;
            endcase
         end
         FN_NULL_RX: begin
            if (mode_ff == ST_STARTED) begin
               mode_in         = ST_CONNECTING;
               phase_in        = cfg.wait_hold;
               char_in         = cfg.char_period;
               result.send_fct = 1'b1;
            end else if (mode_ff == ST_READY) begin
               mode_in          = ST_STARTED;
               phase_in         = cfg.wait_hold;
               char_in          = cfg.char_period;
               result.send_null = 1'b1;
            end
         end
         FN_FCT_RX: begin
            if (mode_ff == ST_CONNECTING) begin
               mode_in           = ST_RUN;
               phase_in          = '0;
               char_in           = '0;
               result.link_ready = 1'b1;
            end
         end
         FN_PKT_RX: begin
            if (item.parity_bad) begin
               go_ereset           = 1'b1;
               result.error_notify = 1'b1;
            end else begin
               result.rx_accept = 1'b1;
            end
         end
         FN_LINK_LOST: begin
            go_ereset  = 1'b1;
            go_silence = 1'b1;
         end
         FN_TX_START: begin
            if (mode_ff == ST_RUN) begin
               mode_in = ST_BUSY;
               tx_in   = tx_load;
            end else begin
               result.tx_rejected = 1'b1;
            end
         end
         FN_LINK_START: begin
            if (mode_ff == ST_DOWN) begin
               go_ereset = 1'b1;
            end
         end
         FN_SHUTDOWN: begin
            mode_in    = ST_DOWN;
            phase_in   = '0;
            char_in    = '0;
            tx_in      = '0;
            silence_in = 1'b0;
         end
         default: ;
      endcase

      if (go_ereset) begin
         mode_in    = ST_ERESET;
         phase_in   = cfg.reset_hold;
         char_in    = '0;
         tx_in      = '0;
         silence_in = 1'b0;
      end
      // link loss holds off the restart for the silence time
      if (go_silence) begin
         phase_in   = cfg.silence;
         silence_in = 1'b1;
      end

      result.link_state = mode_code(mode_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= ST_DOWN;
         phase_ff   <= '0;
         char_ff    <= '0;
         tx_ff      <= '0;
         silence_ff <= 1'b0;
      end else if (step) begin
         mode_ff    <= mode_in;
         phase_ff   <= phase_in;
         char_ff    <= char_in;
         tx_ff      <= tx_in;
         silence_ff <= silence_in;
      end
   end

endmodule

### rtl/spacewire_link_init_fsm.sv
`timescale 1ns / 1ps
// Link start-up and transmit state machine for a SpaceWire-style link.
// Request channel (req_valid / req_stall): one event per beat in req_func,
// with req_parity_bad for packet receive and req_byte_count for transmit
// start. Response channel (rsp_valid / rsp_stall): exactly one beat per
// event, carrying the link state after the event and the per-event flags
// (send NULL, send FCT, link ready, tx done, rx accept, tx rejected,
// error notify).
// A request is taken into the event register, then its state update goes into
// the result register, which raises rsp_valid; a stalled response holds the
// event back. Throughput is one event per cycle while the response is not
// stalled; the event register and the result register let a new request in
// while a response still waits.
// A stalled response holds; req_stall rises only when both registers are
// full and the response is stalled.
// Configuration registers (csr_we / csr_index / csr_wdata) take effect on
// the next event; write them only while no event is in flight.
// Reset puts the link in down with all timers cleared and loads the
// default hold times and periods.
`include "spacewire_link_init_fsm_defines.svh"

module spacewire_link_init_fsm import swl_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CFG_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [2:0]           req_func,
   input  logic                 req_parity_bad,
   input  logic [LEN_W-1:0]     req_byte_count,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [2:0]           rsp_link_state,
   output logic                 rsp_send_null,
   output logic                 rsp_send_fct,
   output logic                 rsp_link_ready,
   output logic                 rsp_tx_done,
   output logic                 rsp_rx_accept,
   output logic                 rsp_tx_rejected,
   output logic                 rsp_error_notify
);

   cfg_type    cfg;
   item_type   s1_item_ff, s1_item_in;
   logic       s1_valid_ff, s1_valid_in;
   result_type result;
   result_type rsp_ff, rsp_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_hold;
   logic       advance;

   swl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   swl_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (s1_item_ff),
      .cfg    (cfg),
      .result (result)
   );

   assign rsp_hold  = rsp_valid_ff & rsp_stall;
   assign advance   = s1_valid_ff & ~rsp_hold;
   assign req_stall = s1_valid_ff & rsp_hold;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_item_in  = s1_item_ff;
      if (!req_stall) begin
         s1_valid_in = req_valid;
         s1_item_in  = '{func: func_type'(req_func), parity_bad: req_parity_bad,
                         byte_count: req_byte_count};
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (!rsp_hold) begin
         rsp_valid_in = s1_valid_ff;
      end
      if (advance) begin
         rsp_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff <= s1_item_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_link_state   = rsp_ff.link_state;
   assign rsp_send_null    = rsp_ff.send_null;
   assign rsp_send_fct     = rsp_ff.send_fct;
   assign rsp_link_ready   = rsp_ff.link_ready;
   assign rsp_tx_done      = rsp_ff.tx_done;
   assign rsp_rx_accept    = rsp_ff.rx_accept;
   assign rsp_tx_rejected  = rsp_ff.tx_rejected;
   assign rsp_error_notify = rsp_ff.error_notify;

   `SWL_ASSERT_IMPLY(a_done_back_in_run, clock, reset, rsp_valid && rsp_tx_done,
      rsp_link_state == LS_RUN && rsp_link_ready)
   `SWL_ASSERT_IMPLY(a_one_char, clock, reset, rsp_valid, !(rsp_send_null && rsp_send_fct))
   `SWL_ASSERT_IMPLY(a_notify_ereset, clock, reset, rsp_valid && rsp_error_notify,
      rsp_link_state == LS_ERESET)
   `SWL_ASSERT_IMPLY(a_reject_not_run, clock, reset, rsp_valid && rsp_tx_rejected,
      rsp_link_state != LS_RUN)
   `SWL_ASSERT_NEXT(a_event_reaches_rsp, clock, reset, s1_valid_ff && !rsp_hold, rsp_valid)

endmodule

### tb/tb_spacewire_link_init_fsm.sv
`timescale 1ns / 1ps

module tb_spacewire_link_init_fsm import swl_pkg::*; ();

   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int RANDOM_PHASES   = 4;
   localparam int PHASE_ITEMS     = 200;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CFG_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;
   logic                 req_valid;
   logic                 req_stall;
   logic [2:0]           req_func;
   logic                 req_parity_bad;
   logic [LEN_W-1:0]     req_byte_count;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [2:0]           rsp_link_state;
   logic                 rsp_send_null;
   logic                 rsp_send_fct;
   logic                 rsp_link_ready;
   logic                 rsp_tx_done;
   logic                 rsp_rx_accept;
   logic                 rsp_tx_rejected;
   logic                 rsp_error_notify;

   spacewire_link_init_fsm u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_parity_bad   (req_parity_bad),
      .req_byte_count   (req_byte_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_link_state   (rsp_link_state),
      .rsp_send_null    (rsp_send_null),
      .rsp_send_fct     (rsp_send_fct),
      .rsp_link_ready   (rsp_link_ready),
      .rsp_tx_done      (rsp_tx_done),
      .rsp_rx_accept    (rsp_rx_accept),
      .rsp_tx_rejected  (rsp_tx_rejected),
      .rsp_error_notify (rsp_error_notify)
   );

   // shadow of the link registers
   logic [CFG_W-1:0] hold_reset;
   logic [CFG_W-1:0] hold_wait;
   logic [CFG_W-1:0] silence_len;
   logic [CFG_W-1:0] char_period;
   logic [CFG_W-1:0] byte_ticks;

   // predicted link state
   link_code_type lm;
   logic [31:0]   phase_left;
   logic [31:0]   char_left;
   logic [31:0]   tx_left;
   logic          silence_wait;

   result_type due_results[$];
   int         mismatches;
   int         beat_no;
   int         quiet_cycles;
   bit         calm;
   bit         hold_off_req;
   int         hold_cnt;
   int         stall_left;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 2);
      if (r < 97) return $urandom_range(3, 8);
      return $urandom_range(20, 50);
   endfunction

   task automatic enter_err_reset();
      lm           = LS_ERESET;
      phase_left   = 32'(hold_reset);
      char_left    = '0;
      tx_left      = '0;
      silence_wait = 1'b0;
   endtask

   // one event through the link state machine, producing its result beat
   task automatic advance_link(input func_type f, input logic pb, input logic [LEN_W-1:0] bc,
                               output result_type r);
      r = '0;
      case (f)
         FN_TICK: begin
            case (lm)
               LS_ERESET: begin
                  if (phase_left <= 1) begin
                     phase_left = '0;
                     if (silence_wait) begin
                        enter_err_reset();
                     end else begin
                        lm         = LS_EWAIT;
                        phase_left = 32'(hold_wait);
                     end
                  end else begin
                     phase_left--;
                  end
               end
               LS_EWAIT: begin
                  // ready is skipped on the way to started
                  if (phase_left <= 1) begin
                     lm          = LS_STARTED;
                     phase_left  = 32'(hold_wait);
                     char_left   = 32'(char_period);
                     r.send_null = 1'b1;
                  end else begin
                     phase_left--;
                  end
               end
               LS_STARTED, LS_CONNECTING: begin
                  if (phase_left <= 1) begin
                     enter_err_reset();
                  end else begin
                     phase_left--;
                     if (char_left <= 1) begin
                        char_left = 32'(char_period);
                        if (lm == LS_STARTED) r.send_null = 1'b1;
                        else r.send_fct = 1'b1;
                     end else begin
                        char_left--;
                     end
                  end
               end
               LS_BUSY: begin
                  if (tx_left <= 1) begin
                     tx_left      = '0;
                     lm           = LS_RUN;
                     r.tx_done    = 1'b1;
                     r.link_ready = 1'b1;
                  end else begin
                     tx_left--;
                  end
               end
               default: ;
            endcase
         end
         FN_NULL_RX: begin
            if (lm == LS_STARTED) begin
               lm         = LS_CONNECTING;
               phase_left = 32'(hold_wait);
               char_left  = 32'(char_period);
               r.send_fct = 1'b1;
            end else if (lm == LS_READY) begin
               lm          = LS_STARTED;
               phase_left  = 32'(hold_wait);
               char_left   = 32'(char_period);
               r.send_null = 1'b1;
            end
         end
         FN_FCT_RX: begin
            if (lm == LS_CONNECTING) begin
               lm           = LS_RUN;
               phase_left   = '0;
               char_left    = '0;
               r.link_ready = 1'b1;
            end
         end
         FN_PKT_RX: begin
            if (pb) begin
               enter_err_reset();
               r.error_notify = 1'b1;
            end else begin
               r.rx_accept = 1'b1;
            end
         end
         FN_LINK_LOST: begin
            enter_err_reset();
            phase_left   = 32'(silence_len);
            silence_wait = 1'b1;
         end
         FN_TX_START: begin
            if (lm == LS_RUN) begin
               // 16 x 16 bits never reaches the 32-bit ceiling
               tx_left = 32'(bc) * 32'(byte_ticks);
               lm      = LS_BUSY;
            end else begin
               r.tx_rejected = 1'b1;
            end
         end
         FN_LINK_START: begin
            if (lm == LS_DOWN) enter_err_reset();
         end
         default: begin
            lm           = LS_DOWN;
            phase_left   = '0;
            char_left    = '0;
            tx_left      = '0;
            silence_wait = 1'b0;
         end
      endcase
      r.link_state = lm;
   endtask

   task automatic send_event(input func_type f, input logic pb, input logic [LEN_W-1:0] bc);
      int gap;
      result_type want;
      gap = calm ? 0 : idle_len();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= f;
      req_parity_bad <= pb;
      req_byte_count <= bc;
      do @(posedge clock); while (req_stall !== 1'b0);
      advance_link(f, pb, bc, want);
      due_results.push_back(want);
   endtask

   // pause the sender until every outstanding beat has come back
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic put_reg(input cfg_idx_type idx, input logic [CFG_W-1:0] v);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      case (idx)
         CFG_RESET_HOLD:     hold_reset  = v;
         CFG_WAIT_HOLD:      hold_wait   = v;
         CFG_SILENCE:        silence_len = v;
         CFG_CHAR_PERIOD:    char_period = v;
         CFG_TICKS_PER_BYTE: byte_ticks  = v;
         default: ;
      endcase
   endtask

   task automatic write_config(input logic [CFG_W-1:0] rh, input logic [CFG_W-1:0] wh,
                               input logic [CFG_W-1:0] sl, input logic [CFG_W-1:0] cp,
                               input logic [CFG_W-1:0] tpb);
      drain();
      put_reg(CFG_RESET_HOLD, rh);
      put_reg(CFG_WAIT_HOLD, wh);
      put_reg(CFG_SILENCE, sl);
      put_reg(CFG_CHAR_PERIOD, cp);
      put_reg(CFG_TICKS_PER_BYTE, tpb);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // mostly legal progress from the predicted state, some noise
   task automatic pick_event(output func_type f, output logic pb, output logic [LEN_W-1:0] bc);
      int r;
      r  = $urandom_range(0, 99);
      f  = FN_TICK;
      pb = 1'b0;
      bc = LEN_W'($urandom_range(0, 6));
      if (r < 12) begin
         f  = func_type'($urandom_range(0, 7));
         pb = 1'($urandom_range(0, 1));
         bc = LEN_W'($urandom);
      end else if (lm != LS_BUSY && lm != LS_DOWN && lm != LS_RUN && phase_left > 400) begin
         f = FN_SHUTDOWN;
      end else begin
         r = $urandom_range(0, 99);
         case (lm)
            LS_DOWN:       f = (r < 15) ? FN_TICK : FN_LINK_START;
            LS_ERESET,
            LS_EWAIT:      f = (r < 8) ? FN_PKT_RX : FN_TICK;
            LS_STARTED:    f = (r < 25) ? FN_NULL_RX : FN_TICK;
            LS_CONNECTING: f = (r < 25) ? FN_FCT_RX : FN_TICK;
            LS_RUN: begin
               if (r < 40) begin
                  f = FN_TX_START;
                  if ($urandom_range(0, 19) == 0) bc = LEN_W'($urandom);
               end else if (r < 60) begin
                  f  = FN_PKT_RX;
                  pb = ($urandom_range(0, 7) == 0);
               end else if (r < 96) begin
                  f = FN_TICK;
               end else begin
                  f = (r < 98) ? FN_LINK_LOST : FN_SHUTDOWN;
               end
            end
            LS_BUSY: begin
               // drop out of a transfer that would take too long
               if (tx_left > 200) begin
                  f  = (r < 40) ? FN_LINK_LOST : ((r < 70) ? FN_SHUTDOWN : FN_PKT_RX);
                  pb = 1'b1;
               end else if (r < 80) begin
                  f = FN_TICK;
               end else if (r < 90) begin
                  f = FN_TX_START;
               end else begin
                  f = FN_PKT_RX;
               end
            end
            default:       f = FN_TICK;
         endcase
      end
   endtask

   task automatic test_reset_defaults();
      send_event(FN_TICK, 1'b0, '0);
      send_event(FN_NULL_RX, 1'b0, '0);
      send_event(FN_FCT_RX, 1'b0, '0);
      send_event(FN_TX_START, 1'b0, '1);
      send_event(FN_PKT_RX, 1'b1, '0);
      send_event(FN_LINK_START, 1'b0, '0);
      send_event(FN_TICK, 1'b0, '0);
      send_event(FN_SHUTDOWN, 1'b0, '0);
   endtask

   task automatic test_bring_up();
      write_config(16'd2, 16'd4, 16'd0, 16'd1, 16'd1);
      send_event(FN_LINK_START, 1'b0, '0);
      send_event(FN_LINK_START, 1'b0, '0);
      repeat (6) send_event(FN_TICK, 1'b0, '0);
      send_event(FN_NULL_RX, 1'b0, '0);
      send_event(FN_TICK, 1'b0, '0);
      send_event(FN_FCT_RX, 1'b0, '0);
      send_event(FN_NULL_RX, 1'b0, '0);
      send_event(FN_TX_START, 1'b0, '0);
      send_event(FN_TX_START, 1'b0, 16'd3);
      send_event(FN_TICK, 1'b0, '0);
      send_event(FN_TX_START, 1'b0, 16'd2);
      send_event(FN_PKT_RX, 1'b0, '0);
      send_event(FN_PKT_RX, 1'b1, '0);
      send_event(FN_LINK_LOST, 1'b0, '0);
      repeat (3) send_event(FN_TICK, 1'b0, '0);
      send_event(FN_SHUTDOWN, 1'b0, '0);
   endtask

   task automatic test_extremes();
      write_config(16'd1, 16'd3, '1, '1, '1);
      calm = 1'b1;
      send_event(FN_LINK_START, 1'b0, '0);
      send_event(FN_TICK, 1'b0, '0);
      while (lm == LS_EWAIT) send_event(FN_TICK, 1'b0, '0);
      send_event(FN_TICK, 1'b0, '0);
      send_event(FN_NULL_RX, 1'b0, '0);
      send_event(FN_FCT_RX, 1'b0, '0);
      send_event(FN_TX_START, 1'b0, '1);
      repeat (3) send_event(FN_TICK, 1'b0, '0);
      send_event(FN_LINK_LOST, 1'b0, '0);
      repeat (2) send_event(FN_TICK, 1'b0, '0);
      send_event(FN_SHUTDOWN, 1'b0, '0);
      calm = 1'b0;
      write_config('1, 16'd1, 16'd0, 16'd1, 16'd1);
      send_event(FN_LINK_START, 1'b0, '0);
      repeat (3) send_event(FN_TICK, 1'b0, '0);
      send_event(FN_LINK_LOST, 1'b0, '0);
      repeat (2) send_event(FN_TICK, 1'b0, '0);
      send_event(FN_SHUTDOWN, 1'b0, '0);
   endtask

   task automatic test_backpressure();
      func_type   f;
      logic       pb;
      logic [LEN_W-1:0] bc;
      write_config(16'd1, 16'd3, 16'd1, 16'd2, 16'd1);
      calm         = 1'b1;
      hold_off_req = 1'b1;
      repeat (30) begin
         pick_event(f, pb, bc);
         send_event(f, pb, bc);
      end
      calm = 1'b0;
      drain();
   endtask

   task automatic test_random();
      func_type   f;
      logic       pb;
      logic [LEN_W-1:0] bc;
      repeat (RANDOM_PHASES) begin
         write_config(CFG_W'($urandom_range(1, 6)), CFG_W'($urandom_range(2, 40)),
                      CFG_W'($urandom_range(0, 8)), CFG_W'($urandom_range(1, 12)),
                      CFG_W'($urandom_range(1, 4)));
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 40 == 0) calm = ($urandom_range(0, 3) == 0);
            pick_event(f, pb, bc);
            send_event(f, pb, bc);
         end
         calm = 1'b0;
      end
   endtask

   initial begin
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      req_valid      = 1'b0;
      req_func       = FN_TICK;
      req_parity_bad = 1'b0;
      req_byte_count = '0;
      hold_reset     = RESET_HOLD_RST;
      hold_wait      = WAIT_HOLD_RST;
      silence_len    = SILENCE_RST;
      char_period    = CHAR_PERIOD_RST;
      byte_ticks     = TICKS_BYTE_RST;
      lm             = LS_DOWN;
      phase_left     = '0;
      char_left      = '0;
      tx_left        = '0;
      silence_wait   = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_bring_up();
      test_extremes();
      test_backpressure();
      test_random();

      drain();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && due_results.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // receiver: random stalls, plus a long hold-off on request
   initial begin
      rsp_stall    = 1'b0;
      hold_off_req = 1'b0;
      hold_cnt     = 0;
      stall_left   = 0;
      calm         = 1'b0;
      mismatches   = 0;
      beat_no      = 0;
      quiet_cycles = 0;
   end

   always @(negedge clock) begin
      if (hold_cnt > 0) begin
         rsp_stall <= 1'b1;
         hold_cnt--;
      end else if (hold_off_req) begin
         hold_off_req = 1'b0;
         hold_cnt     = HOLD_OFF_CYCLES - 1;
         rsp_stall   <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         stall_left = (calm || $urandom_range(0, 2) != 0) ? 0 : idle_len();
         rsp_stall <= (stall_left > 0);
         if (stall_left > 0) stall_left--;
      end
   end

   task automatic check_field(input string name, input logic [2:0] want, input logic [2:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("beat %0d %s: expected %0d, got %0d", beat_no, name, want, got);
      end
   endtask

   always @(posedge clock) begin : check_beats
      result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (due_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("beat %0d arrived with no event outstanding", beat_no);
         end else begin
            want = due_results.pop_front();
            check_field("link_state", want.link_state, rsp_link_state);
            check_field("send_null", 3'(want.send_null), 3'(rsp_send_null));
            check_field("send_fct", 3'(want.send_fct), 3'(rsp_send_fct));
            check_field("link_ready", 3'(want.link_ready), 3'(rsp_link_ready));
            check_field("tx_done", 3'(want.tx_done), 3'(rsp_tx_done));
            check_field("rx_accept", 3'(want.rx_accept), 3'(rsp_rx_accept));
            check_field("tx_rejected", 3'(want.tx_rejected), 3'(rsp_tx_rejected));
            check_field("error_notify", 3'(want.error_notify), 3'(rsp_error_notify));
         end
         beat_no++;
      end
   end

   // end the run when neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid === 1'b1 && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
